// ===== src/ssg_pkg.sv =====
// Shared types and constants for the stream start-code gate.
`default_nettype none

package ssg_pkg;

	// Transaction operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_PULL = 1'b1;

	// Sync mode codes; the spare code behaves as passthrough
	localparam logic [1:0] MODE_PASS     = 2'd0;
	localparam logic [1:0] MODE_VIDEO    = 2'd1;
	localparam logic [1:0] MODE_AC3      = 2'd2;
	localparam logic [1:0] MODE_PASS_ALT = 2'd3;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MODE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LIMIT = 1'b1;

	// Field and state widths
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned LIMIT_W = 12;
	localparam int unsigned SCAN_W  = 12;

	// Reset values
	localparam logic [LIMIT_W-1:0] SEARCH_LIMIT_RST = 12'd2048;
	localparam logic [31:0]        CODE_SHIFT_RST   = 32'hFFFF_FFFF;

	// Start codes
	localparam logic [31:0] VIDEO_SEQ_CODE = 32'h0000_01B3;
	localparam logic [15:0] AC3_SYNC_WORD  = 16'h0B77;
	localparam logic [2:0]  CODE_BYTES     = 3'd4;

	// Per-transaction result handed from the control stage to the output stage
	typedef struct packed {
		logic       from_ram;
		logic [7:0] code_byte;
		logic       out_valid;
		logic       synced;
		logic       overflow;
	} ssg_res_t;

endpackage

`default_nettype wire

// ===== src/ssg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ssg_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; hold data while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/ssg_ctrl.sv =====
// Scan and FIFO control: start-code search, pointers and counts, one transaction a cycle while commit is high.
`default_nettype none

module ssg_ctrl #(
	parameter int unsigned BUF_DEPTH = 4096
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         commit,
	input  wire logic                         op,
	input  wire logic [7:0]                   in_byte,
	input  wire logic [ssg_pkg::MODE_W-1:0]   sync_mode,
	input  wire logic [ssg_pkg::LIMIT_W-1:0]  search_limit,
	output logic                              ram_we,
	output logic      [$clog2(BUF_DEPTH)-1:0] ram_waddr,
	output logic      [7:0]                   ram_wdata,
	output logic                              ram_re,
	output logic      [$clog2(BUF_DEPTH)-1:0] ram_raddr,
	output ssg_pkg::ssg_res_t                 res
);

	import ssg_pkg::*;

	localparam int unsigned AW = $clog2(BUF_DEPTH);
	localparam int unsigned CW = $clog2(BUF_DEPTH + 1);
	localparam int unsigned SW = CW + 1;
	localparam int unsigned PW = AW + 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(BUF_DEPTH - 1);
	localparam logic [SW-1:0] DEPTH_S   = SW'(BUF_DEPTH);
	localparam logic [PW-1:0] DEPTH_P   = PW'(BUF_DEPTH);

	logic [31:0]       code_shift_q, code_shift_n;
	logic [SCAN_W-1:0] scan_count_q, scan_count_n;
	logic              sync_found_q, sync_found_n;
	logic [AW-1:0]     rd_ptr_q, rd_ptr_n;
	logic [AW-1:0]     wr_ptr_q, wr_ptr_n;
	logic [CW-1:0]     rel_count_q, rel_count_n;
	logic [2:0]        prefix_q, prefix_n;

	logic              passthru;
	logic [CW-1:0]     rel0;
	logic [SCAN_W-1:0] scan0;
	logic              sf0;
	logic              full0;
	logic [31:0]       cs_shift;
	logic [SCAN_W-1:0] scan1;
	logic [PW-1:0]     rd_sum;
	logic              we_c;
	logic              re_c;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == LAST_ADDR) ? '0 : p + AW'(1);
	endfunction

	// Next state and result for the transaction in the stage
	always_comb begin
		code_shift_n  = code_shift_q;
		rd_ptr_n      = rd_ptr_q;
		wr_ptr_n      = wr_ptr_q;
		prefix_n      = prefix_q;
		we_c          = 1'b0;
		re_c          = 1'b0;
		res           = '0;

		passthru = (sync_mode == MODE_PASS) || (sync_mode == MODE_PASS_ALT);

		// Release held bytes when passthrough is entered mid-search
		if (passthru && !sync_found_q) begin
			rel0  = rel_count_q + CW'(scan_count_q);
			scan0 = '0;
			sf0   = 1'b1;
		end else begin
			rel0  = rel_count_q;
			scan0 = scan_count_q;
			sf0   = sync_found_q;
		end

		full0    = ({1'b0, rel0} + SW'(scan0)) >= DEPTH_S;
		cs_shift = {code_shift_q[23:0], in_byte};
		scan1    = scan0 + SCAN_W'(1);
		rd_sum   = {1'b0, rd_ptr_q} + PW'(scan1 - SCAN_W'(2));

		rel_count_n  = rel0;
		scan_count_n = scan0;
		sync_found_n = sf0;

		if (op == OP_PULL) begin
			// Serve the head: start-code bytes first, then the store
			if (rel0 != '0) begin
				res.out_valid = 1'b1;
				rel_count_n   = rel0 - CW'(1);
				if (prefix_q != '0) begin
					unique case (prefix_q)
						3'd4:    res.code_byte = VIDEO_SEQ_CODE[31:24];
						3'd3:    res.code_byte = VIDEO_SEQ_CODE[23:16];
						3'd2:    res.code_byte = VIDEO_SEQ_CODE[15:8];
						3'd1:    res.code_byte = VIDEO_SEQ_CODE[7:0];
						default: res.code_byte = 8'h00;
					endcase
					prefix_n = prefix_q - 3'd1;
				end else begin
					res.from_ram = 1'b1;
					re_c         = 1'b1;
					rd_ptr_n     = ptr_inc(rd_ptr_q);
				end
			end
		end else if (sf0) begin
			// Aligned: append or drop on full
			code_shift_n = cs_shift;
			if (full0) begin
				res.overflow = 1'b1;
			end else begin
				we_c        = 1'b1;
				wr_ptr_n    = ptr_inc(wr_ptr_q);
				rel_count_n = rel0 + CW'(1);
			end
		end else if (sync_mode == MODE_VIDEO) begin
			// Video search: discard held bytes, queue the four code bytes
			code_shift_n = cs_shift;
			if (cs_shift == VIDEO_SEQ_CODE) begin
				wr_ptr_n     = rd_ptr_q;
				scan_count_n = '0;
				sync_found_n = 1'b1;
				rel_count_n  = CW'(CODE_BYTES);
				prefix_n     = CODE_BYTES;
			end
		end else begin
			// AC-3 search: hold the byte and look for the sync word
			if (full0) begin
				res.overflow = 1'b1;
			end else begin
				we_c         = 1'b1;
				wr_ptr_n     = ptr_inc(wr_ptr_q);
				code_shift_n = cs_shift;
				scan_count_n = scan1;
				if (cs_shift[15:0] == AC3_SYNC_WORD) begin
					if (scan1 >= SCAN_W'(2)) begin
						rd_ptr_n    = (rd_sum >= DEPTH_P) ? AW'(rd_sum - DEPTH_P)
						                                  : rd_sum[AW-1:0];
						rel_count_n = rel0 + CW'(2);
					end else begin
						rel_count_n = rel0 + CW'(scan1);
					end
					scan_count_n = '0;
					sync_found_n = 1'b1;
				end else if (scan1 >= search_limit) begin
					rel_count_n  = rel0 + CW'(scan1);
					scan_count_n = '0;
					sync_found_n = 1'b1;
				end
			end
		end

		res.synced = sync_found_n;
	end

	// Store port drive, qualified by the commit
	assign ram_we    = we_c & commit;
	assign ram_waddr = wr_ptr_q;
	assign ram_wdata = in_byte;
	assign ram_re    = re_c & commit;
	assign ram_raddr = rd_ptr_q;

	// Advance state on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_shift_q <= CODE_SHIFT_RST;
			scan_count_q <= '0;
			sync_found_q <= 1'b0;
			rd_ptr_q     <= '0;
			wr_ptr_q     <= '0;
			rel_count_q  <= '0;
			prefix_q     <= '0;
		end else if (commit) begin
			code_shift_q <= code_shift_n;
			scan_count_q <= scan_count_n;
			sync_found_q <= sync_found_n;
			rd_ptr_q     <= rd_ptr_n;
			wr_ptr_q     <= wr_ptr_n;
			rel_count_q  <= rel_count_n;
			prefix_q     <= prefix_n;
		end
	end

endmodule

`default_nettype wire

// ===== src/stream_sync_start_gate_core.sv =====
// Top level of the stream start-code gate: handshake pipeline, config registers and store.
//
// Usage: push transactions (operation = push) carry one stream byte each; pull
// transactions return the next released byte, or out_valid low when none is
// released. Every input transaction gives exactly one result transaction.
// Channels use valid/stall: a transaction moves at a clock edge where valid is
// high and stall is low. Configuration is a plain write port (cfg_we, cfg_idx,
// cfg_wdata) to be used only while the gate is idle.
// Flow: a transaction accepted is registered in the input stage, then processed
// and committed as it moves into the result register, from which its result is
// offered; the move waits while the result register is held by a stall.
// Throughput: one transaction per cycle unless the receiver stalls, set by the control
// stage and the one-write/one-read byte store (BUF_DEPTH entries, registered read).
// While the receiver stalls, the result register holds and the input stage
// still takes one more transaction; in_stall rises only when both are full.
// Reset: mode passthrough, search limit 2048, pipeline empty, FIFO empty. The
// store needs no clearing pass, as only written entries are ever read.
`default_nettype none

module stream_sync_start_gate_core #(
	parameter int unsigned BUF_DEPTH = 4096
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           operation,
	input  wire logic [7:0]                     in_byte,
	output logic                                res_valid,
	input  wire logic                           res_stall,
	output logic      [7:0]                     out_byte,
	output logic                                out_valid,
	output logic                                synced,
	output logic                                overflow,
	input  wire logic                           cfg_we,
	input  wire logic [ssg_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [ssg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	import ssg_pkg::*;

	localparam int unsigned AW = $clog2(BUF_DEPTH);

	logic [MODE_W-1:0]  sync_mode_q;
	logic [LIMIT_W-1:0] search_limit_q;

	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	ssg_res_t   res_s2;

	logic       s2_adv;
	logic       s1_move;
	logic       accept;
	ssg_res_t   res_c;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_mode_q    <= MODE_PASS;
			search_limit_q <= SEARCH_LIMIT_RST;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_SYNC_MODE) begin
				sync_mode_q <= cfg_wdata[MODE_W-1:0];
			end else begin
				search_limit_q <= cfg_wdata[LIMIT_W-1:0];
			end
		end
	end

	// Pipeline flow control
	assign s2_adv   = !valid_s2 || !res_stall;
	assign s1_move  = valid_s1 && s2_adv;
	assign in_stall = valid_s1 && !s2_adv;
	assign accept   = in_valid && !in_stall;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= operation;
			byte_s1 <= in_byte;
		end
	end

	ssg_ctrl #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.commit      (s1_move),
		.op          (op_s1),
		.in_byte     (byte_s1),
		.sync_mode   (sync_mode_q),
		.search_limit(search_limit_q),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.res         (res_c)
	);

	ssg_ram #(
		.WIDTH(8),
		.DEPTH(BUF_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Result stage; hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			res_s2 <= res_c;
		end
	end

	assign res_valid = valid_s2;
	assign out_byte  = res_s2.from_ram ? ram_rdata : res_s2.code_byte;
	assign out_valid = res_s2.out_valid;
	assign synced    = res_s2.synced;
	assign overflow  = res_s2.overflow;

	// One transaction per cycle: never a store write and read together
	a_one_store_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("store written and read in the same cycle");

	// A returned byte is only possible once aligned
	a_pull_implies_synced: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && out_valid) |-> synced)
		else $error("byte released before alignment");

	// A pull never flags overflow
	a_pull_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && out_valid) |-> !overflow)
		else $error("overflow flagged on a returned byte");

	// Store read only when the result stage will take its data
	a_read_on_move: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (valid_s1 && s2_adv))
		else $error("store read without a committed transaction");

endmodule

`default_nettype wire

// ===== bench/stream_sync_start_gate_core_test.sv =====
// Self-checking bench for the stream start-code gate: queued stimulus, in-bench gate model.
module stream_sync_start_gate_core_test;
	import ssg_pkg::*;

	localparam int unsigned GATE_DEPTH     = 4096;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned PHASE_TXNS     = 150;

	typedef struct packed {
		logic       op;
		logic [7:0] data;
	} stream_txn_t;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       synced;
		logic       overflow;
	} gate_res_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	logic                  operation = OP_PUSH;
	logic [7:0]            in_byte   = 8'h00;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	logic [7:0]            out_byte;
	logic                  out_valid;
	logic                  synced;
	logic                  overflow;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_SYNC_MODE;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Gate model state and its copy of the registers
	logic [MODE_W-1:0]  gate_mode;
	logic [LIMIT_W-1:0] gate_limit;
	logic [31:0]        gate_shift;
	logic               gate_aligned;
	int unsigned        held_count;
	int unsigned        released_count;
	int unsigned        head_ptr;
	int unsigned        tail_ptr;
	logic [7:0]         gate_store [GATE_DEPTH];

	stream_txn_t stream_txns [$];
	gate_res_t   gate_results_due [$];
	int unsigned queued_count   = 0;
	int unsigned answered_count = 0;
	int unsigned err_count      = 0;
	int unsigned quiet_cycles   = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	logic [31:0] gen_shift;

	stream_sync_start_gate_core #(
		.BUF_DEPTH(GATE_DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.operation(operation),
		.in_byte  (in_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.out_byte (out_byte),
		.out_valid(out_valid),
		.synced   (synced),
		.overflow (overflow),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Append one byte to the modelled FIFO; refuse when it is full
	function automatic logic store_append(input logic [7:0] value);
		if (released_count + held_count >= GATE_DEPTH)
			return 1'b0;
		gate_store[tail_ptr] = value;
		tail_ptr = (tail_ptr + 1) % GATE_DEPTH;
		return 1'b1;
	endfunction

	function automatic void release_held_bytes();
		released_count += held_count;
		held_count = 0;
		gate_aligned = 1'b1;
	endfunction

	// Advance the gate model by one transaction and return its result
	function automatic gate_res_t gate_predict(input logic op, input logic [7:0] value);
		gate_res_t res;
		logic      thru;
		res = '0;
		thru = (gate_mode == MODE_PASS) || (gate_mode == MODE_PASS_ALT);
		if (thru && !gate_aligned)
			release_held_bytes();
		if (op == OP_PULL) begin
			if (released_count != 0) begin
				res.data = gate_store[head_ptr];
				res.valid = 1'b1;
				head_ptr = (head_ptr + 1) % GATE_DEPTH;
				released_count--;
			end
		end else if (gate_aligned) begin
			gate_shift = {gate_shift[23:0], value};
			if (store_append(value))
				released_count++;
			else
				res.overflow = 1'b1;
		end else if (gate_mode == MODE_VIDEO) begin
			gate_shift = {gate_shift[23:0], value};
			if (gate_shift == VIDEO_SEQ_CODE) begin
				// drop anything still held, then queue the four header bytes
				tail_ptr = (head_ptr + released_count) % GATE_DEPTH;
				held_count = 0;
				gate_aligned = 1'b1;
				for (int k = 3; k >= 0; k--) begin
					if (store_append(VIDEO_SEQ_CODE[8*k +: 8]))
						released_count++;
					else
						res.overflow = 1'b1;
				end
			end
		end else if (!store_append(value)) begin
			res.overflow = 1'b1;
		end else begin
			gate_shift = {gate_shift[23:0], value};
			held_count++;
			if (gate_shift[15:0] == AC3_SYNC_WORD) begin
				// release from the first byte of the sync word
				if (held_count >= 2) begin
					head_ptr = (head_ptr + held_count - 2) % GATE_DEPTH;
					held_count = 2;
				end
				release_held_bytes();
			end else if (held_count >= gate_limit) begin
				release_held_bytes();
			end
		end
		res.synced = gate_aligned || thru;
		return res;
	endfunction

	task automatic queue_push(input logic [7:0] value);
		stream_txns.push_back('{op: OP_PUSH, data: value});
		queued_count++;
		gen_shift = {gen_shift[23:0], value};
	endtask

	task automatic queue_pull();
		stream_txns.push_back('{op: OP_PULL, data: 8'($urandom)});
		queued_count++;
	endtask

	// Push a search byte that completes neither the header code nor the sync word
	task automatic queue_search_byte(input logic [7:0] value);
		logic [7:0] b;
		b = value;
		if (gen_shift[7:0] == AC3_SYNC_WORD[15:8] && b == AC3_SYNC_WORD[7:0])
			b = b + 8'd1;
		if (gen_shift[23:0] == VIDEO_SEQ_CODE[31:8] && b == VIDEO_SEQ_CODE[7:0])
			b = b + 8'd1;
		queue_push(b);
	endtask

	// Random search traffic with pulls, partial header codes and lone sync-word bytes
	task automatic queue_search_noise(input int unsigned count);
		int unsigned pick;
		repeat (count) begin
			pick = $urandom_range(0, 9);
			if (pick < 2) begin
				queue_pull();
			end else if (pick < 4) begin
				queue_search_byte(8'h00);
				queue_search_byte(8'h00);
				queue_search_byte(8'h01);
			end else if (pick == 4) begin
				queue_search_byte(AC3_SYNC_WORD[15:8]);
			end else begin
				queue_search_byte(8'($urandom));
			end
		end
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SYNC_MODE)
			gate_mode = value[MODE_W-1:0];
		else
			gate_limit = value[LIMIT_W-1:0];
	endtask

	// Hold until every queued transaction has returned its result
	task automatic wait_idle();
		while (answered_count != queued_count)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [MODE_W-1:0] mode, input logic [LIMIT_W-1:0] limit,
			input int unsigned idle_pct, input int unsigned stall_pct);
		cfg_write(CFG_SYNC_MODE, CFG_DATA_W'(mode));
		cfg_write(CFG_SEARCH_LIMIT, CFG_DATA_W'(limit));
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (PHASE_TXNS) begin
			if ($urandom_range(0, 99) < 55)
				queue_push(8'($urandom));
			else
				queue_pull();
		end
		wait_idle();
	endtask

	// Driver: offer queued transactions, predict each one as it is taken
	always @(posedge clk or negedge arst_n) begin : drive_proc
		stream_txn_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				gate_results_due.push_back(gate_predict(operation, in_byte));
			if (!in_valid || !in_stall) begin
				if (stream_txns.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = stream_txns.pop_front();
					in_valid  <= 1'b1;
					operation <= nxt.op;
					in_byte   <= nxt.data;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each taken result with the oldest one due
	always @(posedge clk or negedge arst_n) begin : watch_proc
		gate_res_t due;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (gate_results_due.size() == 0) begin
					$error("result with none due: out_byte %0h out_valid %0b", out_byte, out_valid);
					err_count++;
				end else begin
					due = gate_results_due.pop_front();
					answered_count++;
					if (due.data !== out_byte) begin
						$error("out_byte: expected %0h, got %0h", due.data, out_byte);
						err_count++;
					end
					if (due.valid !== out_valid) begin
						$error("out_valid: expected %0b, got %0b", due.valid, out_valid);
						err_count++;
					end
					if (due.synced !== synced) begin
						$error("synced: expected %0b, got %0b", due.synced, synced);
						err_count++;
					end
					if (due.overflow !== overflow) begin
						$error("overflow: expected %0b, got %0b", due.overflow, overflow);
						err_count++;
					end
				end
			end
			res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int unsigned        scenario;
		logic [LIMIT_W-1:0] hold_limit;
		gate_mode      = MODE_PASS;
		gate_limit     = SEARCH_LIMIT_RST;
		gate_shift     = CODE_SHIFT_RST;
		gate_aligned   = 1'b0;
		held_count     = 0;
		released_count = 0;
		head_ptr       = 0;
		tail_ptr       = 0;
		gen_shift      = CODE_SHIFT_RST;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Alignment happens once per reset, so pick one way to reach it
		scenario = $urandom_range(0, 4);
		if (scenario != 3)
			hold_limit = 12'd4095;
		else if ($urandom_range(0, 2) == 0)
			hold_limit = 12'd0;
		else if ($urandom_range(0, 1) == 0)
			hold_limit = 12'd1;
		else
			hold_limit = LIMIT_W'($urandom_range(2, 10));

		// Header search: pulls with nothing released, field extremes, noise
		cfg_write(CFG_SYNC_MODE, CFG_DATA_W'(MODE_VIDEO));
		cfg_write(CFG_SEARCH_LIMIT, CFG_DATA_W'(hold_limit));
		queue_pull();
		queue_search_byte(8'h00);
		queue_search_byte(8'hFF);
		queue_pull();
		queue_search_noise(12);
		wait_idle();

		// Sync-word search: hold bytes in the FIFO
		if (scenario != 2) begin
			cfg_write(CFG_SYNC_MODE, CFG_DATA_W'(MODE_AC3));
			queue_search_byte(8'hFF);
			queue_search_byte(8'h00);
			queue_pull();
			queue_search_noise((scenario == 3) ? 30 : 16);
			wait_idle();
		end

		case (scenario)
			0: begin
				// header found while bytes are still held
				cfg_write(CFG_SYNC_MODE, CFG_DATA_W'(MODE_VIDEO));
				queue_search_noise(8);
				queue_push(VIDEO_SEQ_CODE[31:24]);
				queue_push(VIDEO_SEQ_CODE[23:16]);
				queue_push(VIDEO_SEQ_CODE[15:8]);
				queue_push(VIDEO_SEQ_CODE[7:0]);
			end
			1: begin
				// sync word after many held bytes
				queue_search_noise(6);
				queue_push(AC3_SYNC_WORD[15:8]);
				queue_push(AC3_SYNC_WORD[7:0]);
			end
			2: begin
				// sync word completed with a single held byte
				queue_push(AC3_SYNC_WORD[15:8]);
				wait_idle();
				cfg_write(CFG_SYNC_MODE, CFG_DATA_W'(MODE_AC3));
				queue_push(AC3_SYNC_WORD[7:0]);
			end
			3: begin
				// search limit already reached inside the noise
				queue_search_noise(4);
			end
			default: begin
				// passthrough entered while bytes are held
				if ($urandom_range(0, 1) == 0)
					cfg_write(CFG_SYNC_MODE, CFG_DATA_W'(MODE_PASS));
				else
					cfg_write(CFG_SYNC_MODE, CFG_DATA_W'(MODE_PASS_ALT));
				queue_pull();
				queue_push(8'($urandom));
			end
		endcase
		repeat (4) queue_pull();
		wait_idle();

		// Aligned stream under each idling pattern and register setting
		run_phase(MODE_PASS,     12'd1,            0,  0);
		run_phase(MODE_PASS_ALT, SEARCH_LIMIT_RST, 71, 0);
		run_phase(MODE_VIDEO,    12'd0,            0,  71);
		run_phase(MODE_AC3,      12'd4095,         28, 28);

		if (err_count == 0 && gate_results_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
src/ssg_pkg.sv
src/ssg_ram.sv
src/ssg_ctrl.sv
src/stream_sync_start_gate_core.sv
bench/stream_sync_start_gate_core_test.sv
